// File: rtl/core/ptpd_pkg.sv
// Package for the partial top-k pair distance block.
// Holds default sizes, field widths, register indexes and FSM types.
// No dependencies.
package ptpd_pkg;

  // Default sizes handed to the top level
  localparam int MAX_POINTS_DEF  = 64;
  localparam int MAX_COORDS_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths of the stream items
  localparam int PT_W     = 6;
  localparam int COORD_W  = 6;
  localparam int SAMPLE_W = 16;
  localparam int DIST_W   = 32;
  localparam int IN_W     = 40;   // 34 payload bits padded to whole bytes

  // Configuration port
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_METRIC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_K  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COORDS = 2'd2;

  // Item kinds and distance kinds
  localparam logic MODE_WRITE     = 1'b0;
  localparam logic MODE_QUERY     = 1'b1;
  localparam logic METRIC_EUCLID  = 1'b0;
  localparam logic METRIC_COSINE  = 1'b1;

  // Reset values of the registers
  localparam logic [CFG_W-1:0] TOP_K_RST  = 7'd8;
  localparam logic [CFG_W-1:0] COORDS_RST = 7'd64;

  // Unity in Q16.16
  localparam int Q_ONE = 65536;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEL_I,
    ST_SEL_IW,
    ST_SCAN,
    ST_DECIDE,
    ST_ACC_RA,
    ST_ACC_RB,
    ST_ACC_CAP,
    ST_MUL,
    ST_FIN,
    ST_ROOT,
    ST_PROD,
    ST_DIV,
    ST_COS,
    ST_DONE
  } state_e;

  // Which accumulator goes through the square root unit
  typedef enum logic [1:0] {
    RT_SQ,
    RT_NA,
    RT_NB
  } root_e;

  // Product taken in each multiply step
  typedef enum logic [1:0] {
    MS_DIFF,
    MS_AA,
    MS_BB,
    MS_AB
  } mul_e;

endpackage

// File: rtl/core/partial_topk_pair_distance.sv
// Top level of the partial top-k pair distance block.
// Uses ptpd_pkg for sizes, register indexes and FSM types.
//
// A write item is answered with distance 0. A query ranks the used
// coordinates of both points, then accumulates over each coordinate in the
// union of their top-k sets, then takes one or two square roots and, for
// cosine, a restoring division; a zero cosine norm ends it with an error.
// Its length is set by the single read port of the sample memory: every
// rank is found by rescanning the point's row. One query is in work at a
// time; a finished result waits in the output register, and the next item
// is taken once that register is empty or being read.
module partial_topk_pair_distance #(
  parameter int MAX_POINTS  = ptpd_pkg::MAX_POINTS_DEF,
  parameter int MAX_COORDS  = ptpd_pkg::MAX_COORDS_DEF,
  parameter int SAMPLE_BITS = ptpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata: point_a[5:0], point_b[11:6], coord[17:12], sample[33:18], zero pad
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ptpd_pkg::IN_W-1:0]        s_axis_tdata,
  // tuser: mode[0]
  input  logic                             s_axis_tuser,
  // tdata: distance[31:0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ptpd_pkg::DIST_W-1:0]      m_axis_tdata,
  // tuser: error[0]
  output logic                             m_axis_tuser,
  input  logic                             cfg_we_i,
  input  logic [ptpd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ptpd_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int SW    = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int DW    = SW + 1;
  localparam int PRW   = 2 * DW;
  localparam int CNTW  = $clog2(MAX_COORDS + 1);
  localparam int CIW   = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;
  localparam int DEPTH = MAX_POINTS * MAX_COORDS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SQW   = PRW + CNTW;
  localparam int RADW  = (((SQW + 16) % 2) == 0) ? SQW + 16 : SQW + 17;
  localparam int ROOTW = RADW / 2;
  localparam int RMW   = ROOTW + 2;
  localparam int PW    = 2 * ROOTW;
  localparam int DOTW  = SQW + 1;
  localparam int DVW   = SQW + 32;
  localparam int CTW   = $clog2(DVW + 1);

  // Input unpack
  logic                               in_mode;
  logic [ptpd_pkg::PT_W-1:0]          in_pa;
  logic [ptpd_pkg::PT_W-1:0]          in_pb;
  logic [ptpd_pkg::COORD_W-1:0]       in_coord;
  logic [ptpd_pkg::SAMPLE_W-1:0]      in_sample;
  logic                               in_acc;
  logic                               out_free;

  assign in_mode   = s_axis_tuser;
  assign in_pa     = s_axis_tdata[5:0];
  assign in_pb     = s_axis_tdata[11:6];
  assign in_coord  = s_axis_tdata[17:12];
  assign in_sample = s_axis_tdata[33:18];

  // Control state
  ptpd_pkg::state_e              state_q, state_d;
  ptpd_pkg::root_e               root_sel_q;
  ptpd_pkg::mul_e                step_q, pstep_q;
  logic [CNTW-1:0]               i_q, j_q, pj_q, above_q;
  logic                          pend_q, pass_q, pv_q, out_vld_q;
  logic [CTW-1:0]                cnt_q;
  logic                          metric_q;
  logic [ptpd_pkg::CFG_W-1:0]    topk_q, ciu_q;

  // Datapath
  logic [ptpd_pkg::PT_W-1:0]     pa_q, pb_q;
  logic [MAX_COORDS-1:0]         sel_q;
  logic signed [DW-1:0]          vi_q, a_q, b_q;
  logic signed [PRW-1:0]         prod_q;
  logic [SQW-1:0]                sq_q, na2_q, nb2_q;
  logic signed [DOTW-1:0]        dot_q;
  logic [RADW-1:0]               x_q;
  logic [RMW-1:0]                rem_q;
  logic [ROOTW-1:0]              root_q, na_q, nb_q;
  logic [PW-1:0]                 prodn_q;
  logic [DVW-1:0]                dv_q, quo_q;
  logic [PW-1:0]                 drem_q;
  logic                          neg_q;
  logic [ptpd_pkg::DIST_W-1:0]   res_dist_q, out_dist_q;
  logic                          res_err_q, out_err_q;

  // Memory
  logic [SW-1:0]                 mem [DEPTH];
  logic [SW-1:0]                 rd_q;
  logic                          rz_q;
  logic                          mem_we;
  logic [AW-1:0]                 wr_addr, rd_addr;
  logic [ptpd_pkg::PT_W-1:0]     rd_pt;
  logic [CNTW-1:0]               rd_c;
  logic signed [DW-1:0]          rd_val;

  // Combinational helpers
  logic [CNTW-1:0]               n_use;
  logic                          beats;
  logic signed [DW-1:0]          d_w, mul_x, mul_y;
  logic [RMW+1:0]                rt_rem, rt_trial, rt_diff;
  logic                          rt_ge;
  logic [ROOTW-1:0]              root_nx;
  logic [PW:0]                   dv_nx;
  logic                          dv_ge;
  logic [DOTW-1:0]               dot_abs;
  logic [DVW:0]                  cos_sum;
  logic [DVW-1:0]                cos_sub;

  // Handshakes
  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ptpd_pkg::ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_dist_q;
  assign m_axis_tuser  = out_err_q;

  // Coordinates in use, capped at the row length
  always_comb begin
    if (32'(ciu_q) > MAX_COORDS) n_use = CNTW'(MAX_COORDS);
    else                         n_use = CNTW'(ciu_q);
  end

  // Memory addressing
  always_comb begin
    unique case (state_q)
      ptpd_pkg::ST_SEL_I, ptpd_pkg::ST_SCAN: rd_pt = pass_q ? pb_q : pa_q;
      ptpd_pkg::ST_ACC_RB:                   rd_pt = pb_q;
      default:                               rd_pt = pa_q;
    endcase
    rd_c = (state_q == ptpd_pkg::ST_SCAN) ? j_q : i_q;
  end

  assign rd_addr = AW'(rd_pt) * AW'(MAX_COORDS) + AW'(rd_c[CIW-1:0]);
  assign wr_addr = AW'(in_pa) * AW'(MAX_COORDS) + AW'(in_coord);
  assign mem_we  = in_acc && (in_mode == ptpd_pkg::MODE_WRITE) &&
                   (32'(in_pa) < MAX_POINTS) && (32'(in_coord) < MAX_COORDS);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= in_sample[SW-1:0];
    rd_q <= mem[rd_addr];
    rz_q <= !(32'(rd_pt) < MAX_POINTS);
  end

  // Points beyond the store read as zero
  assign rd_val = rz_q ? '0 : DW'($signed(rd_q));

  // Rank compare: higher value, or equal value at a higher index
  assign beats = (rd_val > vi_q) || ((rd_val == vi_q) && (pj_q > i_q));

  // Shared multiplier operands
  assign d_w = a_q - b_q;
  always_comb begin
    unique case (step_q)
      ptpd_pkg::MS_DIFF: begin mul_x = d_w; mul_y = d_w; end
      ptpd_pkg::MS_AA:   begin mul_x = a_q; mul_y = a_q; end
      ptpd_pkg::MS_BB:   begin mul_x = b_q; mul_y = b_q; end
      default:           begin mul_x = a_q; mul_y = b_q; end
    endcase
  end

  // Square root step: one result bit per cycle
  assign rt_rem   = {rem_q, x_q[RADW-1 -: 2]};
  assign rt_trial = (RMW + 2)'({root_q, 2'b01});
  assign rt_ge    = rt_rem >= rt_trial;
  assign rt_diff  = rt_ge ? rt_rem - rt_trial : rt_rem;
  assign root_nx  = {root_q[ROOTW-2:0], rt_ge};

  // Division step: one quotient bit per cycle
  assign dv_nx = {drem_q, dv_q[DVW-1]};
  assign dv_ge = dv_nx >= {1'b0, prodn_q};

  assign dot_abs = (dot_q < 0) ? DOTW'(-dot_q) : DOTW'(dot_q);
  assign cos_sum = (DVW + 1)'(quo_q) + (DVW + 1)'(ptpd_pkg::Q_ONE);
  assign cos_sub = DVW'(ptpd_pkg::Q_ONE) - quo_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptpd_pkg::ST_IDLE: begin
        if (in_acc && (in_mode == ptpd_pkg::MODE_QUERY)) begin
          state_d = (n_use == '0) ? ptpd_pkg::ST_ACC_RA : ptpd_pkg::ST_SEL_I;
        end
      end
      ptpd_pkg::ST_SEL_I:  state_d = ptpd_pkg::ST_SEL_IW;
      ptpd_pkg::ST_SEL_IW: state_d = ptpd_pkg::ST_SCAN;
      ptpd_pkg::ST_SCAN: begin
        if (j_q == n_use) state_d = ptpd_pkg::ST_DECIDE;
      end
      ptpd_pkg::ST_DECIDE: begin
        if (CNTW'(i_q + 1'b1) == n_use && pass_q) state_d = ptpd_pkg::ST_ACC_RA;
        else                                      state_d = ptpd_pkg::ST_SEL_I;
      end
      ptpd_pkg::ST_ACC_RA: begin
        if (i_q == n_use)               state_d = ptpd_pkg::ST_FIN;
        else if (sel_q[i_q[CIW-1:0]])   state_d = ptpd_pkg::ST_ACC_RB;
      end
      ptpd_pkg::ST_ACC_RB:  state_d = ptpd_pkg::ST_ACC_CAP;
      ptpd_pkg::ST_ACC_CAP: state_d = ptpd_pkg::ST_MUL;
      ptpd_pkg::ST_MUL: begin
        if (step_q == ptpd_pkg::MS_AB) state_d = ptpd_pkg::ST_ACC_RA;
      end
      ptpd_pkg::ST_FIN: begin
        if (metric_q == ptpd_pkg::METRIC_EUCLID)     state_d = ptpd_pkg::ST_ROOT;
        else if (na2_q == '0 || nb2_q == '0)        state_d = ptpd_pkg::ST_DONE;
        else                                        state_d = ptpd_pkg::ST_ROOT;
      end
      ptpd_pkg::ST_ROOT: begin
        if (cnt_q == CTW'(ROOTW - 1)) begin
          unique case (root_sel_q)
            ptpd_pkg::RT_SQ: state_d = ptpd_pkg::ST_DONE;
            ptpd_pkg::RT_NB: state_d = ptpd_pkg::ST_PROD;
            default:         state_d = ptpd_pkg::ST_ROOT;
          endcase
        end
      end
      ptpd_pkg::ST_PROD: state_d = ptpd_pkg::ST_DIV;
      ptpd_pkg::ST_DIV: begin
        if (cnt_q == CTW'(DVW - 1)) state_d = ptpd_pkg::ST_COS;
      end
      ptpd_pkg::ST_COS: state_d = ptpd_pkg::ST_DONE;
      ptpd_pkg::ST_DONE: begin
        if (out_free) state_d = ptpd_pkg::ST_IDLE;
      end
      default: state_d = ptpd_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ptpd_pkg::ST_IDLE;
      root_sel_q <= ptpd_pkg::RT_SQ;
      step_q     <= ptpd_pkg::MS_DIFF;
      pstep_q    <= ptpd_pkg::MS_DIFF;
      i_q        <= '0;
      j_q        <= '0;
      pj_q       <= '0;
      above_q    <= '0;
      pend_q     <= 1'b0;
      pass_q     <= 1'b0;
      pv_q       <= 1'b0;
      out_vld_q  <= 1'b0;
      cnt_q      <= '0;
      metric_q   <= ptpd_pkg::METRIC_EUCLID;
      topk_q     <= ptpd_pkg::TOP_K_RST;
      ciu_q      <= ptpd_pkg::COORDS_RST;
    end else begin
      state_q <= state_d;
      pv_q    <= (state_q == ptpd_pkg::ST_MUL);
      pstep_q <= step_q;

      // Configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ptpd_pkg::REG_METRIC: metric_q <= cfg_data_i[0];
          ptpd_pkg::REG_TOP_K:  topk_q   <= cfg_data_i;
          ptpd_pkg::REG_COORDS: ciu_q    <= cfg_data_i;
          default: ;
        endcase
      end

      // Output register
      if ((state_q == ptpd_pkg::ST_DONE && out_free) ||
          (in_acc && in_mode == ptpd_pkg::MODE_WRITE)) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        ptpd_pkg::ST_IDLE: begin
          i_q    <= '0;
          pass_q <= 1'b0;
        end
        ptpd_pkg::ST_SEL_IW: begin
          j_q     <= '0;
          above_q <= '0;
          pend_q  <= 1'b0;
        end
        // Stream the row through the read port, compare in the cycle after the read
        ptpd_pkg::ST_SCAN: begin
          pend_q <= (j_q != n_use);
          pj_q   <= j_q;
          if (j_q != n_use) j_q <= j_q + 1'b1;
          if (pend_q && beats) above_q <= above_q + 1'b1;
        end
        ptpd_pkg::ST_DECIDE: begin
          if (CNTW'(i_q + 1'b1) == n_use) begin
            i_q    <= '0;
            pass_q <= 1'b1;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        ptpd_pkg::ST_ACC_RA: begin
          step_q <= ptpd_pkg::MS_DIFF;
          if (i_q != n_use && !sel_q[i_q[CIW-1:0]]) i_q <= i_q + 1'b1;
        end
        ptpd_pkg::ST_MUL: begin
          step_q <= ptpd_pkg::mul_e'(step_q + 1'b1);
          if (step_q == ptpd_pkg::MS_AB) i_q <= i_q + 1'b1;
        end
        ptpd_pkg::ST_FIN: begin
          cnt_q      <= '0;
          root_sel_q <= (metric_q == ptpd_pkg::METRIC_EUCLID) ? ptpd_pkg::RT_SQ
                                                              : ptpd_pkg::RT_NA;
        end
        ptpd_pkg::ST_ROOT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CTW'(ROOTW - 1) && root_sel_q == ptpd_pkg::RT_NA) begin
            root_sel_q <= ptpd_pkg::RT_NB;
            cnt_q      <= '0;
          end
        end
        ptpd_pkg::ST_PROD: cnt_q <= '0;
        ptpd_pkg::ST_DIV:  cnt_q <= cnt_q + 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    // Products land in the accumulators in the cycle after the multiply step
    if (pv_q) begin
      unique case (pstep_q)
        ptpd_pkg::MS_DIFF: sq_q  <= sq_q  + SQW'($unsigned(prod_q));
        ptpd_pkg::MS_AA:   na2_q <= na2_q + SQW'($unsigned(prod_q));
        ptpd_pkg::MS_BB:   nb2_q <= nb2_q + SQW'($unsigned(prod_q));
        default:           dot_q <= dot_q + DOTW'(prod_q);
      endcase
    end

    if (in_acc) begin
      out_dist_q <= '0;
      out_err_q  <= 1'b0;
    end else if (state_q == ptpd_pkg::ST_DONE && out_free) begin
      out_dist_q <= res_dist_q;
      out_err_q  <= res_err_q;
    end

    unique case (state_q)
      ptpd_pkg::ST_IDLE: begin
        if (in_acc) begin
          pa_q  <= in_pa;
          pb_q  <= in_pb;
          sq_q  <= '0;
          na2_q <= '0;
          nb2_q <= '0;
          dot_q <= '0;
          sel_q <= '0;
        end
      end
      ptpd_pkg::ST_SEL_IW: vi_q <= rd_val;
      ptpd_pkg::ST_DECIDE: begin
        if (32'(above_q) < 32'(topk_q)) sel_q[i_q[CIW-1:0]] <= 1'b1;
      end
      ptpd_pkg::ST_ACC_RB:  a_q <= rd_val;
      ptpd_pkg::ST_ACC_CAP: b_q <= rd_val;
      ptpd_pkg::ST_MUL:     prod_q <= mul_x * mul_y;
      // Pick the first root, or flag a zero norm
      ptpd_pkg::ST_FIN: begin
        rem_q  <= '0;
        root_q <= '0;
        if (metric_q == ptpd_pkg::METRIC_EUCLID) begin
          x_q <= RADW'({sq_q, 16'h0000});
        end else if (na2_q == '0 || nb2_q == '0) begin
          res_dist_q <= '0;
          res_err_q  <= 1'b1;
        end else begin
          x_q <= RADW'({na2_q, 16'h0000});
        end
      end
      ptpd_pkg::ST_ROOT: begin
        x_q    <= {x_q[RADW-3:0], 2'b00};
        rem_q  <= rt_diff[RMW-1:0];
        root_q <= root_nx;
        if (cnt_q == CTW'(ROOTW - 1)) begin
          unique case (root_sel_q)
            // Root stays below 32 bits for every legal size
            ptpd_pkg::RT_SQ: begin
              res_dist_q <= 32'(root_nx);
              res_err_q  <= 1'b0;
            end
            ptpd_pkg::RT_NA: begin
              na_q   <= root_nx;
              x_q    <= RADW'({nb2_q, 16'h0000});
              rem_q  <= '0;
              root_q <= '0;
            end
            default: nb_q <= root_nx;
          endcase
        end
      end
      ptpd_pkg::ST_PROD: begin
        prodn_q <= PW'(na_q) * PW'(nb_q);
        dv_q    <= DVW'({dot_abs[SQW-1:0], 32'h0000_0000});
        drem_q  <= '0;
        quo_q   <= '0;
        neg_q   <= dot_q < 0;
      end
      ptpd_pkg::ST_DIV: begin
        dv_q <= {dv_q[DVW-2:0], 1'b0};
        if (dv_ge) begin
          drem_q <= PW'(dv_nx - {1'b0, prodn_q});
          quo_q  <= {quo_q[DVW-2:0], 1'b1};
        end else begin
          drem_q <= dv_nx[PW-1:0];
          quo_q  <= {quo_q[DVW-2:0], 1'b0};
        end
      end
      // 1 - ratio, clamped at zero below and all ones above
      ptpd_pkg::ST_COS: begin
        res_err_q <= 1'b0;
        if (neg_q) begin
          if (cos_sum > (DVW + 1)'(33'h0_FFFF_FFFF)) res_dist_q <= '1;
          else                                       res_dist_q <= cos_sum[31:0];
        end else if (quo_q >= DVW'(ptpd_pkg::Q_ONE)) begin
          res_dist_q <= '0;
        end else begin
          res_dist_q <= cos_sub[31:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/ptpd_chk.sv
// Port checker for the partial top-k pair distance block, bound to the top.
// Uses ptpd_pkg for item kinds.
module ptpd_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ptpd_pkg::DIST_W-1:0]    m_axis_tdata,
  input logic                           m_axis_tuser
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // An error result carries zero distance
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("error result with nonzero distance");

  // A write transaction is acknowledged in the next cycle with zero
  a_write_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ptpd_pkg::MODE_WRITE
    |=> m_axis_tvalid && m_axis_tdata == '0 && !m_axis_tuser)
    else $error("write not acknowledged");

  // A query never answers in the next cycle, and the input is not ready then
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ptpd_pkg::MODE_QUERY
    |=> !m_axis_tvalid && !s_axis_tready)
    else $error("query result too early");

endmodule

bind partial_topk_pair_distance ptpd_chk u_ptpd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: dv/partial_topk_pair_distance_tb.sv
// Testbench for the partial top-k pair distance block.
// Drives sample writes and pair queries over the stream ports, predicts each result.
// Depends on ptpd_pkg and the partial_topk_pair_distance top level.
`timescale 1ns / 1ps

module partial_topk_pair_distance_tb;

  typedef struct {
    bit [31:0] distance;
    bit        err;
  } dist_result_t;

  // Predicts the distance of every accepted transaction and checks the results in order
  class topk_distance_predictor;
    bit [15:0]    samples [64][64];
    bit           metric;
    int           top_k;
    int           coords_used;
    dist_result_t expected_q [$];
    int           mismatches;

    function new();
      metric      = ptpd_pkg::METRIC_EUCLID;
      top_k       = ptpd_pkg::TOP_K_RST;
      coords_used = ptpd_pkg::COORDS_RST;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [ptpd_pkg::CFG_IDX_W-1:0] idx,
                          logic [ptpd_pkg::CFG_W-1:0] val);
      case (idx)
        ptpd_pkg::REG_METRIC: metric      = val[0];
        ptpd_pkg::REG_TOP_K:  top_k       = val;
        ptpd_pkg::REG_COORDS: coords_used = val;
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x   = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // Mask of the k largest coordinates; ties go to the higher index
    function bit [63:0] top_mask(int p, int n, int k);
      bit [63:0] m;
      int vi, vj, above;
      m = '0;
      for (int i = 0; i < n; i++) begin
        vi = $signed(samples[p][i]);
        above = 0;
        for (int j = 0; j < n; j++) begin
          vj = $signed(samples[p][j]);
          if (vj > vi || (vj == vi && j > i)) above++;
        end
        if (above < k) m[i] = 1'b1;
      end
      return m;
    endfunction

    function void note_input(bit mode, bit [5:0] pa, bit [5:0] pb, bit [5:0] c,
                             bit [15:0] s);
      dist_result_t r;
      bit [63:0] sel;
      int n;
      longint a, b, d, p;
      longint unsigned sq, na2, nb2, dpos, dneg, na, nb, prod, mag, q, rem, res;
      r.distance = '0;
      r.err      = 1'b0;
      sq = 0; na2 = 0; nb2 = 0; dpos = 0; dneg = 0;
      if (mode == ptpd_pkg::MODE_WRITE) begin
        samples[pa][c] = s;
        expected_q.push_back(r);
        return;
      end
      n = coords_used > 64 ? 64 : coords_used;
      sel = top_mask(pa, n, top_k) | top_mask(pb, n, top_k);
      for (int i = 0; i < n; i++) begin
        if (sel[i]) begin
          a = $signed(samples[pa][i]);
          b = $signed(samples[pb][i]);
          d = a - b;
          sq  += d * d;
          na2 += a * a;
          nb2 += b * b;
          p = a * b;
          if (p >= 0) dpos += p;
          else dneg += -p;
        end
      end
      if (metric == ptpd_pkg::METRIC_EUCLID) begin
        res = int_sqrt(sq << 16);
        r.distance = res > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : res[31:0];
      end else if (na2 == 0 || nb2 == 0) begin
        r.err = 1'b1;
      end else begin
        na   = int_sqrt(na2 << 16);
        nb   = int_sqrt(nb2 << 16);
        prod = na * nb;
        mag  = dneg > dpos ? dneg - dpos : dpos - dneg;
        q    = mag / prod;
        rem  = mag % prod;
        for (int i = 0; i < 32; i++) begin
          rem = rem << 1;
          q   = q << 1;
          if (rem >= prod) begin
            rem = rem - prod;
            q   = q | 1;
          end
        end
        if (dneg > dpos) res = ptpd_pkg::Q_ONE + q;
        else res = q >= ptpd_pkg::Q_ONE ? 0 : ptpd_pkg::Q_ONE - q;
        r.distance = res > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : res[31:0];
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(bit [31:0] distance, bit err);
      dist_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: distance=%h err=%b", distance, err);
        return;
      end
      e = expected_q.pop_front();
      if (e.distance !== distance || e.err !== err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected distance=%h err=%b, actual distance=%h err=%b",
                   e.distance, e.err, distance, err);
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [ptpd_pkg::IN_W-1:0]      s_axis_tdata;
  logic                           s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [ptpd_pkg::DIST_W-1:0]    m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           cfg_we_i;
  logic [ptpd_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [ptpd_pkg::CFG_W-1:0]     cfg_data_i;

  topk_distance_predictor dist_pred = new();
  bit   written [64][64];
  bit   no_gaps;
  int   items_sent;
  int   quiet_cycles;

  partial_topk_pair_distance uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: a slow query plus a long stall is well under this
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 60000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls unless no_gaps is set, check each transaction
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin : result_loop
      int stall;
      stall = no_gaps ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      dist_pred.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  task automatic send_item(bit mode, bit [5:0] pa, bit [5:0] pb, bit [5:0] c,
                           bit [15:0] s);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, s, c, pb, pa};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    dist_pred.note_input(mode, pa, pb, c, s);
    if (mode == ptpd_pkg::MODE_WRITE) written[pa][c] = 1'b1;
    items_sent++;
  endtask

  // Lower valid and wait until every result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (dist_pred.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(bit m, bit [6:0] k, bit [6:0] n);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= ptpd_pkg::REG_METRIC;
    cfg_data_i <= {6'b0, m};
    @(posedge clk_i);
    dist_pred.set_reg(ptpd_pkg::REG_METRIC, {6'b0, m});
    cfg_idx_i  <= ptpd_pkg::REG_TOP_K;
    cfg_data_i <= k;
    @(posedge clk_i);
    dist_pred.set_reg(ptpd_pkg::REG_TOP_K, k);
    cfg_idx_i  <= ptpd_pkg::REG_COORDS;
    cfg_data_i <= n;
    @(posedge clk_i);
    dist_pred.set_reg(ptpd_pkg::REG_COORDS, n);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic bit [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bit point_ready(int p, int n);
    for (int c = 0; c < n; c++)
      if (!written[p][c]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic fill_point(int p, int n);
    for (int c = 0; c < n; c++)
      if (!written[p][c])
        send_item(ptpd_pkg::MODE_WRITE, 6'(p), 6'($urandom), 6'(c), pick_sample());
  endtask

  // Pick a point with all used coordinates written, or fill a random point to use
  task automatic pick_point(int n, output int p);
    int ready_q [$];
    for (int i = 0; i < 64; i++)
      if (point_ready(i, n)) ready_q.push_back(i);
    if (ready_q.size() > 0 && (n > 16 || $urandom_range(0, 3) != 0)) begin
      p = ready_q[$urandom_range(0, ready_q.size() - 1)];
    end else begin
      p = $urandom_range(0, 63);
      fill_point(p, n);
    end
  endtask

  task automatic random_phase();
    bit [6:0] n_cfg, k_cfg;
    int n, len, pa, pb, c, p;
    case ($urandom_range(0, 9))
      0: n_cfg = 0;
      1: n_cfg = 32;
      2: n_cfg = 64;
      3: n_cfg = 7'($urandom_range(65, 127));
      default: n_cfg = 7'($urandom_range(1, 10));
    endcase
    case ($urandom_range(0, 5))
      0: k_cfg = 0;
      1: k_cfg = 64;
      2: k_cfg = 127;
      default: k_cfg = 7'($urandom_range(1, n_cfg + 2));
    endcase
    drain();
    no_gaps = ($urandom_range(0, 3) == 0);
    set_config(1'($urandom_range(0, 1)), k_cfg, n_cfg);
    n = n_cfg > 64 ? 64 : n_cfg;
    len = n > 16 ? 10 : 60;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 55) begin
        p = $urandom_range(0, 2) != 0 ? $urandom_range(0, 7) : $urandom_range(0, 63);
        c = (n > 0 && $urandom_range(0, 1)) ? $urandom_range(0, n - 1) : $urandom_range(0, 63);
        send_item(ptpd_pkg::MODE_WRITE, 6'(p), 6'($urandom), 6'(c), pick_sample());
      end else begin
        pick_point(n, pa);
        if ($urandom_range(0, 9) == 0) pb = pa;
        else pick_point(n, pb);
        send_item(ptpd_pkg::MODE_QUERY, 6'(pa), 6'(pb), 6'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ptpd_pkg::MODE_WRITE;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= ptpd_pkg::REG_METRIC;
    cfg_data_i    <= '0;
    no_gaps       = 1'b0;
    items_sent    = 0;
    quiet_cycles  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: full rows, euclidean, top 8
    fill_point(10, 64);
    fill_point(11, 64);
    send_item(ptpd_pkg::MODE_QUERY, 10, 11, 6'h3F, 16'hFFFF);
    send_item(ptpd_pkg::MODE_QUERY, 11, 10, 6'h00, 16'h0000);
    drain();

    // Directed: extremes, ties, zero rows, empty and oversized selections
    set_config(ptpd_pkg::METRIC_EUCLID, 2, 4);
    send_item(ptpd_pkg::MODE_WRITE, 0, 0, 0, 16'h7FFF);
    send_item(ptpd_pkg::MODE_WRITE, 0, 0, 1, 16'h8000);
    send_item(ptpd_pkg::MODE_WRITE, 0, 0, 2, 16'h0000);
    send_item(ptpd_pkg::MODE_WRITE, 0, 0, 3, 16'h7FFF);
    for (int c = 0; c < 4; c++)
      send_item(ptpd_pkg::MODE_WRITE, 1, 0, 6'(c), 16'h0000);
    send_item(ptpd_pkg::MODE_WRITE, 63, 63, 0, 16'hFFFF);
    send_item(ptpd_pkg::MODE_WRITE, 63, 63, 1, 16'h0001);
    send_item(ptpd_pkg::MODE_WRITE, 63, 63, 2, 16'h8000);
    send_item(ptpd_pkg::MODE_WRITE, 63, 63, 63, 16'h0005);
    send_item(ptpd_pkg::MODE_WRITE, 63, 63, 3, 16'h0005);
    send_item(ptpd_pkg::MODE_QUERY, 0, 63, 0, 0);
    send_item(ptpd_pkg::MODE_QUERY, 0, 0, 0, 0);
    send_item(ptpd_pkg::MODE_QUERY, 63, 1, 0, 0);
    drain();
    set_config(ptpd_pkg::METRIC_COSINE, 2, 4);
    send_item(ptpd_pkg::MODE_QUERY, 0, 1, 0, 0);
    send_item(ptpd_pkg::MODE_QUERY, 0, 63, 0, 0);
    send_item(ptpd_pkg::MODE_QUERY, 0, 0, 0, 0);
    drain();
    set_config(ptpd_pkg::METRIC_COSINE, 0, 4);
    send_item(ptpd_pkg::MODE_QUERY, 0, 63, 0, 0);
    drain();
    set_config(ptpd_pkg::METRIC_EUCLID, 127, 4);
    send_item(ptpd_pkg::MODE_QUERY, 63, 0, 0, 0);
    drain();
    set_config(ptpd_pkg::METRIC_COSINE, 127, 0);
    send_item(ptpd_pkg::MODE_QUERY, 0, 63, 0, 0);
    drain();
    set_config(ptpd_pkg::METRIC_EUCLID, 1, 0);
    send_item(ptpd_pkg::MODE_QUERY, 0, 63, 0, 0);

    // Random phases with fresh settings each
    while (items_sent < 1700) random_phase();

    drain();
    repeat (50) @(posedge clk_i);
    if (dist_pred.mismatches == 0 && dist_pred.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ptpd_pkg.sv
rtl/core/partial_topk_pair_distance.sv
rtl/core/ptpd_chk.sv
dv/partial_topk_pair_distance_tb.sv
